// File: src/gmd_pkg.sv
package gmd_pkg;

  // Fixed field widths.
  localparam int COORD_W    = 32;
  localparam int NODE_W     = 5;
  localparam int DENS_W     = 48;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int ADDR_W_MAX = 24;

  // Default grid size per axis.
  localparam int NODES_X = 32;
  localparam int NODES_Y = 32;
  localparam int NODES_Z = 32;

  // Queue depths between front, back and the result port.
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  localparam logic [DENS_W-1:0] DENS_MAX = {DENS_W{1'b1}};

  // Request operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_DEPOSIT = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DROP = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_INV_SX     = 3'd3,
    REG_INV_SY     = 3'd4,
    REG_INV_SZ     = 3'd5,
    REG_INV_VOLUME = 3'd6
  } reg_e;

  // Work kinds handed from the front to the back.
  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_DEPOSIT = 2'd1,
    KIND_READ    = 2'd2,
    KIND_REPORT  = 2'd3
  } kind_e;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_SWEEP = 2'd0,
    BK_IDLE  = 2'd1,
    BK_WAIT  = 2'd2
  } bk_state_e;

  // One classified request.
  typedef struct packed {
    kind_e                 kind;
    status_e               status;
    logic [NODE_W-1:0]     node_x;
    logic [NODE_W-1:0]     node_y;
    logic [NODE_W-1:0]     node_z;
    logic [ADDR_W_MAX-1:0] addr;
    logic [DENS_W-1:0]     inc;
  } cmd_t;

  // One result.
  typedef struct packed {
    status_e           status;
    logic [NODE_W-1:0] node_x;
    logic [NODE_W-1:0] node_y;
    logic [NODE_W-1:0] node_z;
    logic [DENS_W-1:0] density;
  } res_t;

endpackage

// File: src/grid_mass_deposit.sv
// Channel   Direction  Handshake            Payload
// input     in         push / full          operation, pos_x/y/z, particle_mass, read_x/y/z
// result    out        empty / pop          status, node_x/y/z, density
// config    in         cfg_we_i (no wait)   cfg_idx_i, cfg_data_i
//
// A request passes a two-stage front (offset, then multiply and classify) into a
// four-entry queue. The back end serves deposits and reads in IDLE and then WAIT,
// due to the registered RAM read ahead of the write-back; a report ends in IDLE.
// A clear walks the RAM one node a cycle over all NodesX * NodesY * NodesZ nodes.
// After reset the same walk runs and full stays high until it ends.
// With pop low, the front stages and both queues fill up and then full rises.
module grid_mass_deposit #(
  parameter int NodesX = gmd_pkg::NODES_X,
  parameter int NodesY = gmd_pkg::NODES_Y,
  parameter int NodesZ = gmd_pkg::NODES_Z
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [gmd_pkg::OP_W-1:0]           operation_i,
  input  logic signed [gmd_pkg::COORD_W-1:0] pos_x_i,
  input  logic signed [gmd_pkg::COORD_W-1:0] pos_y_i,
  input  logic signed [gmd_pkg::COORD_W-1:0] pos_z_i,
  input  logic [gmd_pkg::COORD_W-1:0]        particle_mass_i,
  input  logic [gmd_pkg::NODE_W-1:0]         read_x_i,
  input  logic [gmd_pkg::NODE_W-1:0]         read_y_i,
  input  logic [gmd_pkg::NODE_W-1:0]         read_z_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [1:0]                         status_o,
  output logic [gmd_pkg::NODE_W-1:0]         node_x_o,
  output logic [gmd_pkg::NODE_W-1:0]         node_y_o,
  output logic [gmd_pkg::NODE_W-1:0]         node_z_o,
  output logic [gmd_pkg::DENS_W-1:0]         density_o,
  input  logic                               cfg_we_i,
  input  logic [gmd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gmd_pkg::COORD_W-1:0]        cfg_data_i
);

  import gmd_pkg::*;

  logic [$bits(cmd_t)-1:0] cmd_in_raw, cmd_out_raw;
  logic [$bits(res_t)-1:0] res_in_raw, res_out_raw;
  cmd_t cmd_in;
  res_t res_in, res_out;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic res_push, res_full;
  logic sweeping;

  gmd_front #(
    .NodesX(NodesX),
    .NodesY(NodesY),
    .NodesZ(NodesZ)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .hold_i         (sweeping),
    .in_push_i      (push),
    .in_full_o      (full),
    .operation_i    (operation_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .particle_mass_i(particle_mass_i),
    .read_x_i       (read_x_i),
    .read_y_i       (read_y_i),
    .read_z_i       (read_z_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_full_i     (cmd_full),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_in)
  );

  assign cmd_in_raw = cmd_in;

  // Queue between the classifier and the store sequencer.
  gmd_fifo #(
    .Width($bits(cmd_t)),
    .Depth(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .full_o (cmd_full),
    .data_i (cmd_in_raw),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .data_o (cmd_out_raw)
  );

  gmd_back #(
    .NodesX(NodesX),
    .NodesY(NodesY),
    .NodesZ(NodesZ)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sweeping_o (sweeping),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .cmd_i      (cmd_t'(cmd_out_raw)),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  assign res_in_raw = res_in;

  // Result queue seen from outside.
  gmd_fifo #(
    .Width($bits(res_t)),
    .Depth(RES_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .full_o (res_full),
    .data_i (res_in_raw),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (res_out_raw)
  );

  assign res_out   = res_t'(res_out_raw);
  assign status_o  = res_out.status;
  assign node_x_o  = res_out.node_x;
  assign node_y_o  = res_out.node_y;
  assign node_z_o  = res_out.node_z;
  assign density_o = res_out.density;

endmodule

// File: src/gmd_ram.sv
module gmd_ram #(
  parameter int Width = 48,
  parameter int Depth = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/gmd_fifo.sv
module gmd_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update with explicit wrap.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: src/gmd_front.sv
module gmd_front #(
  parameter int NodesX = 32,
  parameter int NodesY = 32,
  parameter int NodesZ = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             hold_i,
  input  logic                             in_push_i,
  output logic                             in_full_o,
  input  logic [gmd_pkg::OP_W-1:0]         operation_i,
  input  logic signed [gmd_pkg::COORD_W-1:0] pos_x_i,
  input  logic signed [gmd_pkg::COORD_W-1:0] pos_y_i,
  input  logic signed [gmd_pkg::COORD_W-1:0] pos_z_i,
  input  logic [gmd_pkg::COORD_W-1:0]      particle_mass_i,
  input  logic [gmd_pkg::NODE_W-1:0]       read_x_i,
  input  logic [gmd_pkg::NODE_W-1:0]       read_y_i,
  input  logic [gmd_pkg::NODE_W-1:0]       read_z_i,
  input  logic                             cfg_we_i,
  input  logic [gmd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gmd_pkg::COORD_W-1:0]      cfg_data_i,
  input  logic                             cmd_full_i,
  output logic                             cmd_push_o,
  output gmd_pkg::cmd_t                    cmd_o
);

  import gmd_pkg::*;

  localparam int XW = $clog2(NodesX);
  localparam int YW = $clog2(NodesY);
  localparam int ZW = $clog2(NodesZ);

  // Configuration registers.
  logic [COORD_W-1:0] org_x_q, org_y_q, org_z_q;
  logic [COORD_W-1:0] inv_sx_q, inv_sy_q, inv_sz_q, inv_vol_q;

  // Stage 1: offsets from the grid origin.
  logic                v1_q;
  logic [OP_W-1:0]     op1_q;
  logic [COORD_W:0]    dx1_q, dy1_q, dz1_q;
  logic [COORD_W-1:0]  mass1_q;
  logic [NODE_W-1:0]   rx1_q, ry1_q, rz1_q;

  // Stage 2: scaled positions and mass increment.
  logic                v2_q;
  logic [OP_W-1:0]     op2_q;
  logic                negx2_q, negy2_q, negz2_q;
  logic [2*COORD_W-1:0] px2_q, py2_q, pz2_q;
  logic [DENS_W-1:0]   inc2_q;
  logic [NODE_W-1:0]   rx2_q, ry2_q, rz2_q;

  logic                adv, accept;
  logic [2*COORD_W-1:0] mass_prod;
  logic [COORD_W-1:0]  ix, iy, iz;
  logic                out_x, out_y, out_z, in_box, read_ok;
  cmd_t                cmd;

  // Linear node address, x major and z minor.
  function automatic logic [ADDR_W_MAX-1:0] node_addr(
    input logic [ADDR_W_MAX-1:0] x,
    input logic [ADDR_W_MAX-1:0] y,
    input logic [ADDR_W_MAX-1:0] z
  );
    node_addr = (x * ADDR_W_MAX'(NodesY) + y) * ADDR_W_MAX'(NodesZ) + z;
  endfunction

  assign adv        = !v2_q || !cmd_full_i;
  assign in_full_o  = !adv || hold_i;
  assign accept     = in_push_i && !in_full_o;
  assign cmd_push_o = v2_q && !cmd_full_i;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q   <= '0;
      org_y_q   <= '0;
      org_z_q   <= '0;
      inv_sx_q  <= 32'h0001_0000;
      inv_sy_q  <= 32'h0001_0000;
      inv_sz_q  <= 32'h0001_0000;
      inv_vol_q <= 32'h0001_0000;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_ORIGIN_X:   org_x_q   <= cfg_data_i;
        REG_ORIGIN_Y:   org_y_q   <= cfg_data_i;
        REG_ORIGIN_Z:   org_z_q   <= cfg_data_i;
        REG_INV_SX:     inv_sx_q  <= cfg_data_i;
        REG_INV_SY:     inv_sy_q  <= cfg_data_i;
        REG_INV_SZ:     inv_sz_q  <= cfg_data_i;
        REG_INV_VOLUME: inv_vol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage valid bits move together and hold while stage 2 is valid and the queue is full.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  assign mass_prod = 64'(mass1_q) * 64'(inv_vol_q);

  // Stage payloads: subtract in the first, multiply in the second.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q   <= operation_i;
      dx1_q   <= {pos_x_i[COORD_W-1], pos_x_i} - {org_x_q[COORD_W-1], org_x_q};
      dy1_q   <= {pos_y_i[COORD_W-1], pos_y_i} - {org_y_q[COORD_W-1], org_y_q};
      dz1_q   <= {pos_z_i[COORD_W-1], pos_z_i} - {org_z_q[COORD_W-1], org_z_q};
      mass1_q <= particle_mass_i;
      rx1_q   <= read_x_i;
      ry1_q   <= read_y_i;
      rz1_q   <= read_z_i;

      op2_q   <= op1_q;
      negx2_q <= dx1_q[COORD_W];
      negy2_q <= dy1_q[COORD_W];
      negz2_q <= dz1_q[COORD_W];
      px2_q   <= 64'(dx1_q[COORD_W-1:0]) * 64'(inv_sx_q);
      py2_q   <= 64'(dy1_q[COORD_W-1:0]) * 64'(inv_sy_q);
      pz2_q   <= 64'(dz1_q[COORD_W-1:0]) * 64'(inv_sz_q);
      inc2_q  <= mass_prod[2*COORD_W-1:16];
      rx2_q   <= rx1_q;
      ry2_q   <= ry1_q;
      rz2_q   <= rz1_q;
    end
  end

  // Box check: the scaled position may not pass the last node.
  assign ix    = px2_q[2*COORD_W-1:COORD_W];
  assign iy    = py2_q[2*COORD_W-1:COORD_W];
  assign iz    = pz2_q[2*COORD_W-1:COORD_W];
  assign out_x = (ix > COORD_W'(NodesX - 1)) ||
                 ((ix == COORD_W'(NodesX - 1)) && (px2_q[COORD_W-1:0] != '0));
  assign out_y = (iy > COORD_W'(NodesY - 1)) ||
                 ((iy == COORD_W'(NodesY - 1)) && (py2_q[COORD_W-1:0] != '0));
  assign out_z = (iz > COORD_W'(NodesZ - 1)) ||
                 ((iz == COORD_W'(NodesZ - 1)) && (pz2_q[COORD_W-1:0] != '0));
  assign in_box = !negx2_q && !negy2_q && !negz2_q && !out_x && !out_y && !out_z;

  assign read_ok = (COORD_W'(rx2_q) < COORD_W'(NodesX)) &&
                   (COORD_W'(ry2_q) < COORD_W'(NodesY)) &&
                   (COORD_W'(rz2_q) < COORD_W'(NodesZ));

  // Classify the request for the back end.
  always_comb begin
    cmd        = '0;
    cmd.kind   = KIND_REPORT;
    cmd.status = ST_OK;
    case (op_e'(op2_q))
      OP_CLEAR: begin
        cmd.kind = KIND_CLEAR;
      end
      OP_DEPOSIT: begin
        if (in_box) begin
          cmd.kind   = KIND_DEPOSIT;
          cmd.node_x = ix[NODE_W-1:0];
          cmd.node_y = iy[NODE_W-1:0];
          cmd.node_z = iz[NODE_W-1:0];
          cmd.addr   = node_addr(ADDR_W_MAX'(ix[XW-1:0]), ADDR_W_MAX'(iy[YW-1:0]),
                                 ADDR_W_MAX'(iz[ZW-1:0]));
          cmd.inc    = inc2_q;
        end else begin
          cmd.status = ST_DROP;
        end
      end
      OP_READ: begin
        cmd.node_x = rx2_q;
        cmd.node_y = ry2_q;
        cmd.node_z = rz2_q;
        if (read_ok) begin
          cmd.kind = KIND_READ;
          cmd.addr = node_addr(ADDR_W_MAX'(rx2_q), ADDR_W_MAX'(ry2_q), ADDR_W_MAX'(rz2_q));
        end else begin
          cmd.status = ST_DROP;
        end
      end
      default: ;
    endcase
  end

  assign cmd_o = cmd;

endmodule

// File: src/gmd_back.sv
module gmd_back #(
  parameter int NodesX = 32,
  parameter int NodesY = 32,
  parameter int NodesZ = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          sweeping_o,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  input  gmd_pkg::cmd_t cmd_i,
  input  logic          res_full_i,
  output logic          res_push_o,
  output gmd_pkg::res_t res_o
);

  import gmd_pkg::*;

  localparam int Depth = NodesX * NodesY * NodesZ;
  localparam int AW    = $clog2(Depth);

  bk_state_e         state_q, state_d;
  logic [AW-1:0]     sweep_q, sweep_d;
  logic              clear_pend_q, clear_pend_d;
  cmd_t              cur_q;

  logic              take, sweep_last;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DENS_W-1:0] ram_wdata, ram_rdata;
  logic [DENS_W:0]   sum;
  res_t              res;

  gmd_ram #(
    .Width(DENS_W),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // A request is taken only when its result is sure to find room.
  assign take       = (state_q == BK_IDLE) && !cmd_empty_i && !res_full_i;
  assign sweep_last = (sweep_q == AW'(Depth - 1));
  assign sum        = {1'b0, ram_rdata} + {1'b0, cur_q.inc};
  assign sweeping_o = (state_q == BK_SWEEP) && !clear_pend_q;

  // Next state.
  always_comb begin
    state_d      = state_q;
    sweep_d      = sweep_q;
    clear_pend_d = clear_pend_q;
    case (state_q)
      BK_SWEEP: begin
        sweep_d = sweep_q + 1'b1;
        if (sweep_last) begin
          state_d      = BK_IDLE;
          sweep_d      = '0;
          clear_pend_d = 1'b0;
        end
      end
      BK_IDLE: begin
        if (take) begin
          case (cmd_i.kind)
            KIND_CLEAR: begin
              state_d      = BK_SWEEP;
              clear_pend_d = 1'b1;
            end
            KIND_DEPOSIT, KIND_READ: state_d = BK_WAIT;
            default: ;
          endcase
        end
      end
      BK_WAIT: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // Memory control and result generation.
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = sweep_q;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = cmd_i.addr[AW-1:0];
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res        = '0;
    res.status = ST_OK;
    case (state_q)
      BK_SWEEP: begin
        ram_we     = 1'b1;
        res_push_o = sweep_last && clear_pend_q;
      end
      BK_IDLE: begin
        cmd_pop_o = take;
        ram_re    = take;
        if (take && (cmd_i.kind == KIND_REPORT)) begin
          res_push_o = 1'b1;
          res.status = cmd_i.status;
          res.node_x = cmd_i.node_x;
          res.node_y = cmd_i.node_y;
          res.node_z = cmd_i.node_z;
        end
      end
      BK_WAIT: begin
        res_push_o = 1'b1;
        res.status = cur_q.status;
        res.node_x = cur_q.node_x;
        res.node_y = cur_q.node_y;
        res.node_z = cur_q.node_z;
        res.density = ram_rdata;
        if (cur_q.kind == KIND_DEPOSIT) begin
          ram_we    = 1'b1;
          ram_waddr = cur_q.addr[AW-1:0];
          if (sum[DENS_W]) begin
            res.status  = ST_SAT;
            res.density = DENS_MAX;
          end else begin
            res.density = sum[DENS_W-1:0];
          end
          ram_wdata = res.density;
        end
      end
      default: ;
    endcase
  end

  assign res_o = res;

  // Control state; the store is swept clean after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_SWEEP;
      sweep_q      <= '0;
      clear_pend_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_q      <= sweep_d;
      clear_pend_q <= clear_pend_d;
    end
  end

  // Request held while its memory read is in flight.
  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q <= cmd_i;
    end
  end

endmodule

// File: src/gmd_checker.sv
module gmd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input logic [1:0]                 status_o,
  input logic [gmd_pkg::DENS_W-1:0] density_o
);

  import gmd_pkg::*;

  // The store is being swept right after reset, so no request may enter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> full)
    else $error("request accepted before the post-reset sweep");

  // A dropped point or out-of-grid read never reports a density.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o == ST_DROP)) |-> (density_o == '0))
    else $error("dropped result carries a density");

  // Saturation always leaves the node at full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o == ST_SAT)) |-> (density_o == DENS_MAX))
    else $error("saturated result below full scale");

  // A waiting result stays put until it is popped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(density_o)))
    else $error("waiting result changed before pop");

endmodule

bind grid_mass_deposit gmd_checker u_gmd_checker (.*);
